FILE: src/cca_pkg.sv
// ============================================================================
// cca_pkg: shared constants and types for the color centroid aim offset core
// Field widths, register indexes, reset values and default parameter values.
// ============================================================================
package cca_pkg;

    // Default sizing of the image the core can handle.
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Depth of the queue between the pixel front end and the angle back end.
    localparam int QUEUE_DEPTH = 2;

    // Fixed field widths.
    localparam int CHAN_W      = 8;
    localparam int ANGLE_W     = 16;
    localparam int GAIN_W      = 15;
    localparam int FWIDTH_W    = 13;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH     = 1'b0,
        REG_ANGLE_STEP_GAIN = 1'b1
    } cca_reg_t;

    // Register reset values.
    localparam logic [FWIDTH_W-1:0] FRAME_WIDTH_RST = 13'd640;
    localparam logic [GAIN_W-1:0]   GAIN_RST        = 15'd1608;

endpackage

FILE: src/cca_front.sv
// ============================================================================
// cca_front: pixel classifier and centroid accumulator
// Holds the configuration registers, tracks the column, sums target columns
// and counts target pixels; hands one frame record on at each frame end.
// ============================================================================
module cca_front #(
    parameter int MAX_WIDTH  = cca_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cca_pkg::DEF_MAX_HEIGHT,
    parameter int COL_W      = $clog2(MAX_WIDTH),
    parameter int WID_W      = $clog2(MAX_WIDTH + 1),
    parameter int CNT_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
    parameter int SUM_W      = CNT_W + COL_W
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Pixel stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // Fields from bit 0 up: chan_zero, chan_one, chan_two, present_aim.
    input  logic [cca_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                               s_tlast,
    // Configuration writes.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cca_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cca_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Frame record toward the queue.
    output logic                               frm_valid,
    input  logic                               frm_ready,
    output logic [CNT_W-1:0]                   frm_count,
    output logic [SUM_W-1:0]                   frm_sum,
    output logic [WID_W-1:0]                   frm_width,
    output logic [cca_pkg::GAIN_W-1:0]         frm_gain,
    output logic [cca_pkg::ANGLE_W-1:0]        frm_angle
);
    import cca_pkg::*;

    localparam logic [CNT_W-1:0]    HIT_CAP   = CNT_W'(MAX_WIDTH * MAX_HEIGHT);
    localparam logic [FWIDTH_W-1:0] WIDTH_MAX = FWIDTH_W'(MAX_WIDTH);

    logic [FWIDTH_W-1:0] frame_width_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic [CHAN_W-1:0]   c0, c1, c2;
    logic [FWIDTH_W-1:0] w_eff;
    logic [COL_W:0]      col_inc;
    logic                hit;
    logic                take;

    assign c0 = s_tdata[CHAN_W-1:0];
    assign c1 = s_tdata[2*CHAN_W-1:CHAN_W];
    assign c2 = s_tdata[3*CHAN_W-1:2*CHAN_W];

    assign cfg_ready = 1'b1;
    assign s_tready  = frm_ready;
    assign take      = s_tvalid && frm_ready;

    // A width of zero acts as one; anything above the maximum is clamped.
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = FWIDTH_W'(1);
        end
        else if (frame_width_reg > WIDTH_MAX)
        begin
            w_eff = WIDTH_MAX;
        end
        else
        begin
            w_eff = frame_width_reg;
        end
    end

    assign hit     = (c2 > c1) && (c2 > c0) && (cnt_reg < HIT_CAP);
    assign col_inc = {1'b0, col_reg} + (COL_W+1)'(1);

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (hit)
        begin
            sum_next = sum_reg + SUM_W'(col_reg);
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (FWIDTH_W'(col_inc) >= w_eff)
        begin
            col_next = '0;
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
        end
    end

    assign frm_valid = s_tvalid && s_tlast;
    assign frm_count = cnt_next;
    assign frm_sum   = sum_next;
    assign frm_width = w_eff[WID_W-1:0];
    assign frm_gain  = gain_reg;
    assign frm_angle = s_tdata[3*CHAN_W+ANGLE_W-1:3*CHAN_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= FRAME_WIDTH_RST;
            gain_reg        <= GAIN_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_FRAME_WIDTH)
            begin
                frame_width_reg <= cfg_data[FWIDTH_W-1:0];
            end
            else if (cfg_index == REG_ANGLE_STEP_GAIN)
            begin
                gain_reg <= cfg_data[GAIN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (take)
        begin
            if (s_tlast)
            begin
                col_reg <= '0;
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            else
            begin
                col_reg <= col_next;
                sum_reg <= sum_next;
                cnt_reg <= cnt_next;
            end
        end
    end

endmodule

FILE: src/cca_queue.sv
// ============================================================================
// cca_queue: short first-in first-out queue of frame records
// Decouples the pixel front end from the multi-cycle angle back end.
// ============================================================================
module cca_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = cca_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);
    import cca_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

FILE: src/cca_back.sv
// ============================================================================
// cca_back: aim angle computation for one frame record
// Multiplies, scales and divides one bit per cycle, then adds and saturates
// into the output register.
// ============================================================================
module cca_back #(
    parameter int MAX_WIDTH  = cca_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cca_pkg::DEF_MAX_HEIGHT,
    parameter int COL_W      = $clog2(MAX_WIDTH),
    parameter int WID_W      = $clog2(MAX_WIDTH + 1),
    parameter int CNT_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
    parameter int SUM_W      = CNT_W + COL_W
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    output logic                               q_ready,
    input  logic [CNT_W-1:0]                   q_count,
    input  logic [SUM_W-1:0]                   q_sum,
    input  logic [WID_W-1:0]                   q_width,
    input  logic [cca_pkg::GAIN_W-1:0]         q_gain,
    input  logic [cca_pkg::ANGLE_W-1:0]        q_angle,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cca_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tuser
);
    import cca_pkg::*;

    localparam int DEN_W  = CNT_W + WID_W;
    localparam int DIF_W  = ((DEN_W > SUM_W) ? DEN_W : SUM_W) + 1;
    localparam int MAG_W  = DIF_W - 1;
    localparam int PROD_W = MAG_W + GAIN_W;
    localparam int ITER_W = $clog2(PROD_W);
    localparam int RES_W  = PROD_W + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUB,
        ST_SCALE,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t                    state_reg, state_next;
    logic                      m_tvalid_reg, m_tvalid_next;

    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [WID_W-1:0]          width_reg, width_next;
    logic [GAIN_W-1:0]         gain_reg, gain_next;
    logic signed [ANGLE_W-1:0] angle_reg, angle_next;
    logic [DEN_W-1:0]          half_prod_reg, half_prod_next;
    logic [DEN_W-1:0]          den_reg, den_next;
    logic                      neg_reg, neg_next;
    logic [MAG_W-1:0]          mag_reg, mag_next;
    logic [PROD_W-1:0]         quo_reg, quo_next;
    logic [DEN_W-1:0]          rem_reg, rem_next;
    logic [ITER_W-1:0]         iter_reg, iter_next;
    logic [ANGLE_W-1:0]        data_reg, data_next;
    logic                      found_reg, found_next;

    logic [DIF_W-1:0]          diff;
    logic [DIF_W-1:0]          diff_abs;
    logic [DEN_W:0]            rem_shift;
    logic                      qbit;
    logic [RES_W-1:0]          q_ext, dx, cur_ext, res;
    logic                      res_ovf;
    logic                      out_load;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = found_reg;

    // Signed numerator: count * floor(width / 2) - column sum.
    assign diff     = DIF_W'(half_prod_reg) - DIF_W'(sum_reg);
    assign diff_abs = diff[DIF_W-1] ? (~diff + DIF_W'(1)) : diff;

    // One restoring division step.
    assign rem_shift = {rem_reg, quo_reg[PROD_W-1]};
    assign qbit      = (rem_shift >= {1'b0, den_reg});

    // Final add and saturation.
    assign q_ext   = RES_W'(quo_reg);
    assign dx      = neg_reg ? (~q_ext + RES_W'(1)) : q_ext;
    assign cur_ext = RES_W'(angle_reg);
    assign res     = cur_ext + dx;
    assign res_ovf = !((&res[RES_W-1:ANGLE_W-1]) || !(|res[RES_W-1:ANGLE_W-1]));

    always_comb
    begin
        state_next     = state_reg;
        m_tvalid_next  = m_tvalid_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        width_next     = width_reg;
        gain_next      = gain_reg;
        angle_next     = angle_reg;
        half_prod_next = half_prod_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        iter_next      = iter_reg;
        data_next      = data_reg;
        found_next     = found_reg;
        q_ready        = 1'b0;
        out_load       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_ready    = 1'b1;
                    cnt_next   = q_count;
                    sum_next   = q_sum;
                    width_next = q_width;
                    gain_next  = q_gain;
                    angle_next = q_angle;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    // No target: the correction is the gain itself.
                    quo_next   = PROD_W'(gain_reg);
                    neg_next   = 1'b0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    half_prod_next = DEN_W'(cnt_reg) * DEN_W'(width_reg >> 1);
                    den_next       = DEN_W'(cnt_reg) * DEN_W'(width_reg);
                    state_next     = ST_SUB;
                end
            end
            ST_SUB:
            begin
                neg_next   = diff[DIF_W-1];
                mag_next   = diff_abs[MAG_W-1:0];
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                quo_next   = PROD_W'(mag_reg) * PROD_W'(gain_reg);
                rem_next   = '0;
                iter_next  = ITER_W'(PROD_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (qbit)
                begin
                    rem_next = DEN_W'(rem_shift - {1'b0, den_reg});
                end
                else
                begin
                    rem_next = rem_shift[DEN_W-1:0];
                end
                quo_next  = {quo_reg[PROD_W-2:0], qbit};
                iter_next = iter_reg - ITER_W'(1);
                if (iter_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            found_next    = (cnt_reg != '0);
            if (res_ovf)
            begin
                data_next = res[RES_W-1] ? {1'b1, {(ANGLE_W-1){1'b0}}}
                                         : {1'b0, {(ANGLE_W-1){1'b1}}};
            end
            else
            begin
                data_next = res[ANGLE_W-1:0];
            end
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        sum_reg       <= sum_next;
        width_reg     <= width_next;
        gain_reg      <= gain_next;
        angle_reg     <= angle_next;
        half_prod_reg <= half_prod_next;
        den_reg       <= den_next;
        neg_reg       <= neg_next;
        mag_reg       <= mag_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        iter_reg      <= iter_next;
        data_reg      <= data_next;
        found_reg     <= found_next;
    end

endmodule

FILE: src/color_centroid_aim_offset_core.sv
// ============================================================================
// color_centroid_aim_offset_core: color blob centroid aim tracker
// Finds the column centroid of target pixels in a frame and turns its offset
// from the image center into a corrected aim angle.
// ============================================================================
// Throughput: one pixel per cycle while the queue has room, one angle result per frame.
// A frame-end record runs the back-end states multiply, subtract, scale, divide (53
//   steps at default parameters) and finish; with no target, multiply skips to finish.
// Up to two frame records wait in a queue; the pixel input stalls only when it is full.
// Reset (rst_n, asynchronous, active low) clears the accumulators, the queue and
//   the output, and loads the default width and gain.
module color_centroid_aim_offset_core #(
    parameter int MAX_WIDTH  = cca_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cca_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Pixel input: one transaction per pixel, tlast marks the frame end.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // Fields from bit 0 up: chan_zero[7:0], chan_one[15:8], chan_two[23:16],
    // present_aim[39:24].
    input  logic [cca_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                               s_tlast,
    // Result output: one transaction per frame.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // Fields from bit 0 up: new_aim[15:0].
    output logic [cca_pkg::M_TDATA_W-1:0]      m_tdata,
    // Fields from bit 0 up: target_found[0].
    output logic                               m_tuser,
    // Configuration write channel: index 0 frame_width, index 1 angle_step_gain.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cca_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cca_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import cca_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SUM_W = CNT_W + COL_W;
    localparam int ENT_W = CNT_W + SUM_W + WID_W + GAIN_W + ANGLE_W;

    // Frame record produced by the front end at each frame-end pixel.
    logic                frm_valid, frm_ready;
    logic [CNT_W-1:0]    frm_count;
    logic [SUM_W-1:0]    frm_sum;
    logic [WID_W-1:0]    frm_width;
    logic [GAIN_W-1:0]   frm_gain;
    logic [ANGLE_W-1:0]  frm_angle;

    // Same record as it leaves the queue.
    logic                q_valid, q_ready;
    logic [ENT_W-1:0]    q_data;

    // The front end classifies every pixel and accumulates; it never waits on
    // the divider unless the queue is full.
    cca_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_W      (COL_W),
        .WID_W      (WID_W),
        .CNT_W      (CNT_W),
        .SUM_W      (SUM_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready),
        .frm_count (frm_count),
        .frm_sum   (frm_sum),
        .frm_width (frm_width),
        .frm_gain  (frm_gain),
        .frm_angle (frm_angle)
    );

    // The width and gain travel with each record, so the back end works on the
    // values that were in force when the frame ended.
    cca_queue #(
        .DATA_W (ENT_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (frm_valid),
        .in_ready  (frm_ready),
        .in_data   ({frm_angle, frm_gain, frm_width, frm_sum, frm_count}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    // The back end runs the correction arithmetic; its output register lets
    // the next record start while a result waits to be taken.
    cca_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_W      (COL_W),
        .WID_W      (WID_W),
        .CNT_W      (CNT_W),
        .SUM_W      (SUM_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_count  (q_data[CNT_W-1:0]),
        .q_sum    (q_data[CNT_W+SUM_W-1:CNT_W]),
        .q_width  (q_data[CNT_W+SUM_W+WID_W-1:CNT_W+SUM_W]),
        .q_gain   (q_data[CNT_W+SUM_W+WID_W+GAIN_W-1:CNT_W+SUM_W+WID_W]),
        .q_angle  (q_data[ENT_W-1:CNT_W+SUM_W+WID_W+GAIN_W]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: src/cca_checker.sv
// ============================================================================
// cca_checker: port-level checks for the color centroid aim offset core
// Tracks frames in flight and checks results against them.
// ============================================================================
module cca_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic                               s_tlast,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [cca_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                               m_tuser
);
    import cca_pkg::*;

    // Queue entries, the record in the back end and the output register.
    localparam int MAX_PENDING = QUEUE_DEPTH + 2;
    localparam int PEND_W      = $clog2(MAX_PENDING + 2);

    logic [PEND_W-1:0] pending_reg;
    logic              frame_in, result_out;

    assign frame_in   = s_tvalid && s_tready && s_tlast;
    assign result_out = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (frame_in && !result_out)
        begin
            pending_reg <= pending_reg + PEND_W'(1);
        end
        else if (result_out && !frame_in)
        begin
            pending_reg <= pending_reg - PEND_W'(1);
        end
    end

    // A stalled result holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // No result without a frame end that has not yet been answered.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != '0)
        else $error("result without a pending frame");

    // Frames in flight never exceed the buffering of the design.
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PEND_W'(MAX_PENDING))
        else $error("too many frames in flight");

    // The pixel input only stalls while at least QUEUE_DEPTH frames are in flight.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> pending_reg >= PEND_W'(QUEUE_DEPTH))
        else $error("pixel input stalled with the queue not full");

endmodule

bind color_centroid_aim_offset_core cca_checker u_cca_checker (.*);

FILE: bench/cca_aim_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// cca_aim_checker: result checker for the color centroid aim offset core
// Watches the pixel, result and configuration channels, keeps its own copy of
// the accumulators and registers, predicts the aim angle of every frame and
// compares each result transaction against the oldest prediction.
// ============================================================================
module cca_aim_checker
    import cca_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   s_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   m_tuser,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     outstanding
);

    localparam longint HIT_LIMIT = longint'(DEF_MAX_WIDTH) * longint'(DEF_MAX_HEIGHT);

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic               found;
    } aim_t;

    aim_t                aim_expected[$];
    logic [FWIDTH_W-1:0] width_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [11:0]         column;
    logic [35:0]         column_sum;
    logic [24:0]         hit_total;
    int                  miss_n;
    int                  result_n;

    function automatic logic [ANGLE_W-1:0] clamp_angle(input longint v);
        if (v > 32767)
        begin
            return 16'h7FFF;
        end
        if (v < -32768)
        begin
            return 16'h8000;
        end
        return v[ANGLE_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        logic [12:0] w_eff;
        logic [12:0] next_col;
        logic [7:0]  c0, c1, c2;
        longint      cur, cnt, half, sum_l, w_l, gain_l, num, den, dx;
        aim_t        aim;
        aim_t        got;
        if (!rst_n)
        begin
            aim_expected.delete();
            width_reg  = FRAME_WIDTH_RST;
            gain_reg   = GAIN_RST;
            column     = '0;
            column_sum = '0;
            hit_total  = '0;
            miss_n     = 0;
            result_n   = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cca_reg_t'(cfg_index))
                    REG_FRAME_WIDTH:     width_reg = cfg_data[FWIDTH_W-1:0];
                    REG_ANGLE_STEP_GAIN: gain_reg  = cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                c0  = s_tdata[7:0];
                c1  = s_tdata[15:8];
                c2  = s_tdata[23:16];
                cur = $signed(s_tdata[39:24]);
                if (width_reg == '0)
                begin
                    w_eff = 13'd1;
                end
                else if (width_reg > 13'(DEF_MAX_WIDTH))
                begin
                    w_eff = 13'(DEF_MAX_WIDTH);
                end
                else
                begin
                    w_eff = width_reg;
                end

                // The pixel uses the stored column even if it lies past a
                // width that was lowered mid-row; the counter wraps after.
                if ((c2 > c1) && (c2 > c0) && (longint'(hit_total) < HIT_LIMIT))
                begin
                    column_sum = column_sum + 36'(column);
                    hit_total  = hit_total + 25'd1;
                end
                next_col = {1'b0, column} + 13'd1;
                if (next_col >= w_eff)
                begin
                    next_col = '0;
                end
                column = next_col[11:0];

                if (s_tlast)
                begin
                    gain_l = longint'(gain_reg);
                    if (hit_total == '0)
                    begin
                        aim.angle = clamp_angle(cur + gain_l);
                        aim.found = 1'b0;
                    end
                    else
                    begin
                        cnt   = longint'(hit_total);
                        half  = longint'(w_eff >> 1);
                        sum_l = longint'(column_sum);
                        w_l   = longint'(w_eff);
                        num   = cnt * half - sum_l;
                        den   = cnt * w_l;
                        dx    = (num * gain_l) / den;
                        aim.angle = clamp_angle(cur + dx);
                        aim.found = 1'b1;
                    end
                    aim_expected.push_back(aim);
                    column     = '0;
                    column_sum = '0;
                    hit_total  = '0;
                end
            end

            if (m_tvalid && m_tready)
            begin
                got.angle = m_tdata;
                got.found = m_tuser;
                if (aim_expected.size() == 0)
                begin
                    if (miss_n < 10)
                    begin
                        $display("result %0d: unexpected, angle %0d found %0b",
                                 result_n, $signed(got.angle), got.found);
                    end
                    miss_n++;
                end
                else
                begin
                    aim = aim_expected.pop_front();
                    if (got != aim)
                    begin
                        if (miss_n < 10)
                        begin
                            $display("result %0d: expected angle %0d found %0b, got angle %0d found %0b",
                                     result_n, $signed(aim.angle), aim.found,
                                     $signed(got.angle), got.found);
                        end
                        miss_n++;
                    end
                end
                result_n++;
            end

            mismatches  <= miss_n;
            outstanding <= aim_expected.size();
        end
    end

endmodule

FILE: bench/tb_color_centroid_aim_offset_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_color_centroid_aim_offset_core: testbench for the centroid aim core
// Drives pixel frames and register writes into the core, lets the checker
// predict and compare every angle result, and reports the verdict.
// ============================================================================
module tb_color_centroid_aim_offset_core;

    import cca_pkg::*;

    // Ways of filling a frame with pixels. Background pixels never qualify as
    // target, tie pixels have the third channel equal to the largest of the
    // other two, and sparse frames hold a few targets at random columns.
    typedef enum int {
        PIX_RANDOM,
        PIX_BACKGROUND,
        PIX_TARGET,
        PIX_TIE,
        PIX_SPARSE
    } pix_mode_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int   mismatches;
    int   outstanding;

    // When calm is set neither side inserts idle cycles. hold_req asks the
    // result side for one long hold-off so that the core backs up.
    logic calm;
    logic hold_req;

    color_centroid_aim_offset_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cca_aim_checker aim_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Safety net: the slowest correct run finishes far sooner than this.
    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

    // Result side. Normally it drops tready about 15 percent of the time. On the
    // first hold request it keeps tready low while the pixel side goes on offering
    // short frames, so the internal queue fills and the pixel input has to stall.
    initial
    begin : result_sink
        int   hold_left;
        logic hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = 500;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= calm || ($urandom_range(0, 99) >= 15);
            end
        end
    end

    // Builds one pixel as {chan_two, chan_one, chan_zero}.
    function automatic logic [23:0] make_pixel(input pix_mode_t mode);
        logic [7:0] c0, c1, c2;
        pix_mode_t  pick;
        pick = mode;
        if (mode == PIX_SPARSE)
        begin
            pick = ($urandom_range(0, 99) < 15) ? PIX_TARGET : PIX_BACKGROUND;
        end
        c0 = 8'($urandom);
        c1 = 8'($urandom);
        c2 = 8'($urandom);
        case (pick)
            PIX_BACKGROUND:
            begin
                // One of the other channels is at least as large as chan_two.
                if ($urandom_range(0, 1) == 0)
                begin
                    c0 = 8'($urandom_range(c2, 255));
                end
                else
                begin
                    c1 = 8'($urandom_range(c2, 255));
                end
            end
            PIX_TARGET:
            begin
                c2 = 8'($urandom_range(1, 255));
                c1 = 8'($urandom_range(0, c2 - 1));
                c0 = 8'($urandom_range(0, c2 - 1));
            end
            PIX_TIE:
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    c1 = c2;
                    c0 = 8'($urandom_range(0, c2));
                end
                else
                begin
                    c0 = c2;
                    c1 = 8'($urandom_range(0, c2));
                end
            end
            default: ;
        endcase
        return {c2, c1, c0};
    endfunction

    // Offers one pixel transaction and returns at the edge where it is taken.
    // A random idle gap may come first; valid stays high between back-to-back
    // pixels so it is never lowered and raised in the same step.
    task automatic send_pixel(input logic [23:0] rgb, input logic last,
                              input logic [ANGLE_W-1:0] ang);
        if (!calm && ($urandom_range(0, 99) < 8))
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ang, rgb};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
    endtask

    // Sends len pixels; the last carries tlast when ends is set. The angle is
    // only used at the frame end, but every pixel gets a fresh one.
    task automatic send_frame(input int len, input pix_mode_t mode, input logic ends);
        logic [ANGLE_W-1:0] ang;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 9))
                0:       ang = 16'h7FFF;
                1:       ang = 16'h8000;
                2:       ang = 16'h0000;
                default: ang = 16'($urandom);
            endcase
            send_pixel(make_pixel(mode), ends && (i == len - 1), ang);
        end
    endtask

    // Stops offering pixels, waits until every predicted angle has come back
    // and then a while longer, since a trailing pixel with no frame end may
    // still be on its way through the core.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(input cca_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Registers are only written once the core has gone quiet.
    task automatic configure(input logic [CFG_DATA_W-1:0] width_data,
                             input logic [CFG_DATA_W-1:0] gain_data);
        settle();
        write_reg(REG_FRAME_WIDTH, width_data);
        write_reg(REG_ANGLE_STEP_GAIN, gain_data);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int                    rnd_items;
        int                    phase_no;
        int                    nominal;
        int                    len;
        int                    nframes;
        logic [CFG_DATA_W-1:0] width_data;
        logic [CFG_DATA_W-1:0] gain_data;

        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= '0;
        calm      <= 1'b0;
        hold_req  <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first with the reset width of 640 and gain of 1608.
        // A frame with no target pixel adds the gain, here past the top of
        // the angle range.
        send_pixel({8'd0, 8'd0, 8'd0}, 1'b1, 16'h0000);
        send_pixel({8'd255, 8'd255, 8'd255}, 1'b1, 16'h7FFF);
        // A single target in column 0 from the most negative angle.
        send_pixel({8'd255, 8'd0, 8'd0}, 1'b1, 16'h8000);
        // Ties with either other channel do not count; then two targets.
        send_pixel({8'd255, 8'd0, 8'd255}, 1'b0, 16'h5555);
        send_pixel({8'd255, 8'd255, 8'd0}, 1'b0, 16'hAAAA);
        send_pixel({8'd255, 8'd254, 8'd254}, 1'b0, 16'hFFFF);
        send_pixel({8'd1, 8'd0, 8'd0}, 1'b1, 16'h1234);

        // Width above the maximum is used as the maximum; bits above the
        // register width are dropped. Gain at its top saturates upward.
        configure(16'hFFFF, 16'hFFFF);
        send_pixel({8'd255, 8'd0, 8'd0}, 1'b1, 16'h7FFF);

        // Width zero is used as one, so every pixel sits in column 0.
        configure(16'd0, 16'd0);
        send_pixel({8'd200, 8'd10, 8'd20}, 1'b0, 16'h0001);
        send_pixel({8'd90, 8'd80, 8'd70}, 1'b1, 16'hC000);
        send_pixel({8'd5, 8'd9, 8'd9}, 1'b1, 16'h7FFF);

        // A target in the rightmost column with full gain saturates downward.
        configure(16'd3, 16'd32767);
        send_pixel({8'd0, 8'd10, 8'd10}, 1'b0, 16'h0000);
        send_pixel({8'd10, 8'd0, 8'd10}, 1'b0, 16'h0000);
        send_pixel({8'd128, 8'd127, 8'd127}, 1'b1, 16'h8000);

        // Width lowered in the middle of a row: ten pixels leave the column
        // counter at 10, then the width drops to 4 and the next target is
        // summed at column 10 before the counter wraps.
        configure(16'd16, 16'd1608);
        send_frame(10, PIX_BACKGROUND, 1'b0);
        configure(16'd4, 16'd1608);
        send_pixel({8'd77, 8'd3, 8'd4}, 1'b1, 16'h0800);
        send_pixel({8'd77, 8'd3, 8'd4}, 1'b0, 16'h0000);
        send_pixel({8'd0, 8'd3, 8'd4}, 1'b1, 16'h0000);

        // Random part: each phase picks a width and gain, then sends a few
        // frames. Most frames are whole rows of the chosen width so the
        // centroid spans real columns; the rest have arbitrary length.
        rnd_items = 0;
        phase_no  = 0;
        while (rnd_items < 1600)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    nominal    = $urandom_range(1, 16);
                    width_data = 16'(nominal);
                end
                6:
                begin
                    nominal    = $urandom_range(17, 300);
                    width_data = 16'(nominal);
                end
                7:
                begin
                    case ($urandom_range(0, 3))
                        0:       nominal = 1;
                        1:       nominal = 2;
                        2:       nominal = DEF_MAX_WIDTH;
                        default: nominal = 0;
                    endcase
                    width_data = 16'(nominal);
                    if (nominal == 0)
                    begin
                        nominal = 1;
                    end
                end
                8:
                begin
                    nominal    = 0;
                    width_data = 16'($urandom);
                end
                default:
                begin
                    // Junk in the bits above the register width.
                    nominal    = $urandom_range(1, 8);
                    width_data = {3'($urandom), 13'(nominal)};
                end
            endcase
            case ($urandom_range(0, 4))
                0:       gain_data = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'd32767;
                1:       gain_data = 16'($urandom);
                default: gain_data = 16'($urandom_range(0, 32767));
            endcase
            if (phase_no == 12)
            begin
                width_data = 16'd8191;
            end

            configure(width_data, gain_data);
            calm <= (phase_no >= 6) && (phase_no < 10);

            if (phase_no == 3)
            begin
                // Long hold-off on the result side while short frames keep
                // coming, so the core runs out of room and stalls its input.
                hold_req <= 1'b1;
                for (int f = 0; f < 10; f++)
                begin
                    len = $urandom_range(1, 4);
                    send_frame(len, PIX_RANDOM, 1'b1);
                    rnd_items += len;
                end
            end

            if (phase_no == 12)
            begin
                // One long frame at the clamped maximum width with targets
                // only toward its end, reaching columns far above the rest.
                send_frame(928, PIX_BACKGROUND, 1'b0);
                send_frame(96, PIX_TARGET, 1'b1);
                rnd_items += 1024;
            end

            nframes = $urandom_range(2, 6);
            for (int f = 0; f < nframes; f++)
            begin
                if ((nominal > 0) && (nominal <= 32) && ($urandom_range(0, 99) < 80))
                begin
                    len = nominal * $urandom_range(1, 3);
                end
                else
                begin
                    len = $urandom_range(1, 48);
                end
                send_frame(len, pix_mode_t'($urandom_range(0, 4)), 1'b1);
                rnd_items += len;
            end
            phase_no++;
        end

        // Everything is sent; wait for the last angles and a margin for any
        // stray result, then give the verdict.
        settle();
        if ((mismatches == 0) && (outstanding == 0))
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
